// File: rtl/soit_pkg.sv
// Shared constants, codes and structs of the sorted offset index table.
package soit_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int KEY_W       = 32;
	localparam int OFF_W       = 32;

	typedef enum logic [1:0] {
		ACT_LOOKUP = 2'd0,
		ACT_SET    = 2'd1,
		ACT_RECENT = 2'd2,
		ACT_SHIFT  = 2'd3
	} action_t;

	// Broadcast to every cell with each accepted request
	typedef struct packed {
		logic             en;
		logic             lookup;
		logic             set;
		logic             shift;
		logic             ins_ok;
		logic [KEY_W-1:0] key;
		logic [OFF_W-1:0] val;
	} cell_cmd_t;

	// Where a cell sits relative to the fill level
	typedef struct packed {
		logic occ;
		logic at_end;
	} cell_pos_t;

	// Compare results a cell reports
	typedef struct packed {
		logic eq;
		logic gt;
		logic le;
		logic match;
	} cell_stat_t;

	// Recent pair snapshot taken with a lookup
	typedef struct packed {
		logic             hit;
		logic [KEY_W-1:0] key;
		logic [OFF_W-1:0] off;
	} recent_t;

endpackage

// File: rtl/soit_in_if.sv
// Request channel: action, key and offset with valid/ready.
interface soit_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [31:0] key_time;
	logic [31:0] offset_value;

	modport source (output valid, action, key_time, offset_value, input ready);
	modport sink   (input valid, action, key_time, offset_value, output ready);
endinterface

// File: rtl/soit_out_if.sv
// Result channel: found offset and drop flag with valid/ready.
interface soit_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] found_offset;
	logic        insert_dropped;

	modport source (output valid, found_offset, insert_dropped, input ready);
	modport sink   (input valid, found_offset, insert_dropped, output ready);
endinterface

// File: rtl/soit_cell.sv
// One table cell: holds a key/offset pair, compares, shifts and adds in place.
module soit_cell (
	input  logic                     clk,
	input  soit_pkg::cell_cmd_t      cmd,
	input  soit_pkg::cell_pos_t      pos,
	input  logic                     gt_prev,
	input  logic [31:0]              key_prev,
	input  logic [31:0]              off_prev,
	input  logic                     le_next,
	output soit_pkg::cell_stat_t     stat,
	output logic [31:0]              key_out,
	output logic [31:0]              off_out,
	output logic [31:0]              sel_key,
	output logic [31:0]              sel_off
);
	import soit_pkg::*;

	logic [KEY_W-1:0] key_q;
	logic [OFF_W-1:0] off_q;

	// Compare the stored key against the request key
	always_comb begin
		stat.eq    = pos.occ && (key_q == cmd.key);
		stat.gt    = pos.occ && (key_q > cmd.key);
		stat.le    = pos.occ && (key_q <= cmd.key);
		stat.match = stat.le && !le_next;
	end

	// Offer this pair to the lookup reduction when it is the floor match
	always_comb begin
		sel_key = (cmd.lookup && stat.match) ? key_q : '0;
		sel_off = (cmd.lookup && stat.match) ? off_q : '0;
	end

	assign key_out = key_q;
	assign off_out = off_q;

	// Replace, shift right, insert or add delta
	always_ff @(posedge clk) begin
		if (cmd.en) begin
			if (cmd.set && stat.eq) begin
				off_q <= cmd.val;
			end else if (cmd.ins_ok && gt_prev) begin
				key_q <= key_prev;
				off_q <= off_prev;
			end else if (cmd.ins_ok && (stat.gt || pos.at_end)) begin
				key_q <= cmd.key;
				off_q <= cmd.val;
			end else if (cmd.shift && stat.gt) begin
				off_q <= off_q + cmd.val;
			end
		end
	end

endmodule

// File: rtl/soit_reduce.sv
// Merge the per-cell lookup candidates and settle against the recent pair.
module soit_reduce (
	input  logic [31:0]       sel_key_s1 [soit_pkg::TABLE_DEPTH],
	input  logic [31:0]       sel_off_s1 [soit_pkg::TABLE_DEPTH],
	input  soit_pkg::recent_t recent_s1,
	output logic [31:0]       found
);
	import soit_pkg::*;

	logic [KEY_W-1:0] mkey;
	logic [OFF_W-1:0] moff;

	// OR together the candidates: at most one cell is non-zero
	always_comb begin
		mkey = '0;
		moff = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			mkey = mkey | sel_key_s1[i];
			moff = moff | sel_off_s1[i];
		end
	end

	// Recent pair wins when it qualifies and is not below the table match
	assign found = (recent_s1.hit && (recent_s1.key >= mkey)) ? recent_s1.off : moff;

endmodule

// File: rtl/sorted_offset_index_table_top.sv
// Top level: chain of table cells, lookup reduction and result register.
// A result passes through the stage one register and then the result register once its request is accepted.
// Throughput: one request per cycle while the result register drains; every cell
// compares, shifts or adds in parallel, so set and shift complete in the accept cycle.
// Lookup reads through the stage one register, an OR merge of the cells and the result register.
// Reset clears the fill count, the recent pair and all valid flags;
// stored pairs are undefined until written.
module sorted_offset_index_table_top (
	input  logic       clk,
	input  logic       arst_n,
	soit_in_if.sink    req,
	soit_out_if.source rsp
);
	import soit_pkg::*;

	action_t          act;
	logic             acc;
	logic             adv;
	logic             full;
	logic             eq_any;
	cell_cmd_t        cmd;
	logic [CNT_W-1:0] count_q;
	logic [KEY_W-1:0] recent_key_q;
	logic [OFF_W-1:0] recent_off_q;

	cell_stat_t       stat    [TABLE_DEPTH];
	cell_pos_t        pos     [TABLE_DEPTH];
	logic [KEY_W-1:0] key_c   [TABLE_DEPTH];
	logic [OFF_W-1:0] off_c   [TABLE_DEPTH];
	logic [KEY_W-1:0] sel_key [TABLE_DEPTH];
	logic [OFF_W-1:0] sel_off [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] eq_vec;
	logic [TABLE_DEPTH-1:0] match_vec;

	logic             v_s1;
	logic             drop_s1;
	recent_t          recent_s1;
	logic [KEY_W-1:0] sel_key_s1 [TABLE_DEPTH];
	logic [OFF_W-1:0] sel_off_s1 [TABLE_DEPTH];
	logic [OFF_W-1:0] found;

	logic             out_v_q;
	logic [OFF_W-1:0] found_q;
	logic             drop_q;

	// Handshake: stage one moves on when the result register is free
	assign adv       = v_s1 && (!out_v_q || rsp.ready);
	assign req.ready = !v_s1 || adv;
	assign acc       = req.valid && req.ready;
	assign act       = action_t'(req.action);
	assign full      = (count_q == CNT_W'(TABLE_DEPTH));
	assign eq_any    = |eq_vec;

	// Decode the request into the cell command
	always_comb begin
		cmd        = '0;
		cmd.en     = acc;
		cmd.key    = req.key_time;
		cmd.val    = req.offset_value;
		case (act)
			ACT_LOOKUP: cmd.lookup = 1'b1;
			ACT_SET:    cmd.set    = 1'b1;
			ACT_SHIFT:  cmd.shift  = 1'b1;
			default:    cmd.lookup = 1'b0;
		endcase
		cmd.ins_ok = cmd.set && !eq_any && !full;
	end

	// Build the cell chain
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		logic             gt_prev;
		logic [KEY_W-1:0] key_prev;
		logic [OFF_W-1:0] off_prev;
		logic             le_next;

		assign pos[i].occ    = (CNT_W'(i) < count_q);
		assign pos[i].at_end = (CNT_W'(i) == count_q);
		assign eq_vec[i]     = stat[i].eq;
		assign match_vec[i]  = stat[i].match;

		if (i == 0) begin : g_first
			assign gt_prev  = 1'b0;
			assign key_prev = '0;
			assign off_prev = '0;
		end else begin : g_rest
			assign gt_prev  = stat[i-1].gt;
			assign key_prev = key_c[i-1];
			assign off_prev = off_c[i-1];
		end

		if (i == TABLE_DEPTH - 1) begin : g_last
			assign le_next = 1'b0;
		end else begin : g_inner
			assign le_next = stat[i+1].le;
		end

		soit_cell u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.pos      (pos[i]),
			.gt_prev  (gt_prev),
			.key_prev (key_prev),
			.off_prev (off_prev),
			.le_next  (le_next),
			.stat     (stat[i]),
			.key_out  (key_c[i]),
			.off_out  (off_c[i]),
			.sel_key  (sel_key[i]),
			.sel_off  (sel_off[i])
		);
	end

	// Advance the fill count and the recent pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			recent_key_q <= '0;
			recent_off_q <= '0;
		end else if (acc) begin
			if (cmd.ins_ok) begin
				count_q <= count_q + 1'b1;
			end
			if (act == ACT_RECENT) begin
				recent_key_q <= req.key_time;
				recent_off_q <= req.offset_value;
			end else if (cmd.shift && (recent_key_q > req.key_time)) begin
				recent_off_q <= recent_off_q + req.offset_value;
			end
		end
	end

	// Stage one control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	// Stage one payload: lookup candidates and drop flag
	always_ff @(posedge clk) begin
		if (acc) begin
			drop_s1       <= cmd.set && !eq_any && full;
			recent_s1.hit <= cmd.lookup && (req.key_time >= recent_key_q);
			recent_s1.key <= recent_key_q;
			recent_s1.off <= recent_off_q;
			sel_key_s1    <= sel_key;
			sel_off_s1    <= sel_off;
		end
	end

	soit_reduce u_reduce (
		.sel_key_s1 (sel_key_s1),
		.sel_off_s1 (sel_off_s1),
		.recent_s1  (recent_s1),
		.found      (found)
	);

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			found_q <= found;
			drop_q  <= drop_s1;
		end
	end

	assign rsp.valid          = out_v_q;
	assign rsp.found_offset   = found_q;
	assign rsp.insert_dropped = drop_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("fill count beyond table depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && cmd.ins_ok) |=> (count_q == $past(count_q) + 1'b1))
		else $error("insert did not advance fill count");

	a_match_single: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match_vec))
		else $error("more than one floor match in the table");

	a_drop_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && cmd.set && full) |=> (count_q == $past(count_q)))
		else $error("fill count moved on a full table");
`endif

endmodule
